// ===== hw/rtl/rcdbus_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdbus_pkg
// Shared types and constants for the remote-control frame decoder.
// ----------------------------------------------------------------------------
package rcdbus_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
    localparam int CH_W        = 11;
    localparam int LIMIT_W     = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int OUT_TDATA_W = 144;

    localparam logic [CH_W-1:0]    STICK_MIN_RST    = 11'd364;
    localparam logic [CH_W-1:0]    STICK_MAX_RST    = 11'd1684;
    localparam logic [CH_W-1:0]    STICK_CENTER_RST = 11'd1024;
    localparam logic [LIMIT_W-1:0] LOSS_LIMIT_RST   = 8'd20;
    localparam logic [1:0]         SW_MIDDLE        = 2'd3;
    localparam logic [1:0]         SW_INVALID       = 2'd0;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_TICK = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STICK_MIN    = 2'd0,
        CFG_STICK_MAX    = 2'd1,
        CFG_STICK_CENTER = 2'd2,
        CFG_LOSS_LIMIT   = 2'd3
    } cfg_addr_t;

    typedef logic [FRAME_BYTES-1:0][7:0] burst_t;

    typedef struct packed {
        logic [4*CH_W-1:0]  sticks;
        logic [3:0]         switches;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        buttons;
        logic [15:0]        keys;
        logic [CH_W-1:0]    wheel;
    } frame_t;

    typedef struct packed {
        logic [CH_W-1:0]    stick_min;
        logic [CH_W-1:0]    stick_max;
        logic [CH_W-1:0]    stick_center;
        logic [LIMIT_W-1:0] loss_limit;
    } cfg_t;

    typedef struct packed {
        kind_t  kind;
        frame_t frame;
        logic   frame_error;
        logic   link_lost;
    } result_t;

endpackage

// ===== hw/rtl/rcdbus_burst.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdbus_burst
// Burst byte buffer and saturating burst length counter.
// ----------------------------------------------------------------------------
module rcdbus_burst #(
    parameter int MAX_BURST = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          mode,
    input  logic [7:0]          data_byte,
    output rcdbus_pkg::burst_t  burst,
    output logic                full
);
    import rcdbus_pkg::*;

    localparam int CNT_W = $clog2(MAX_BURST + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    burst_t           bytes_reg;

    always_comb
    begin
        count_next = count_reg;
        if (accept && mode == MODE_BYTE && count_reg < CNT_W'(MAX_BURST))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept && mode == MODE_IDLE)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_BYTE && count_reg < CNT_W'(FRAME_BYTES))
        begin
            bytes_reg[count_reg[BYTE_IDX_W-1:0]] <= data_byte;
        end
    end

    assign burst = bytes_reg;
    assign full  = (count_reg == CNT_W'(FRAME_BYTES));

endmodule

// ===== hw/rtl/rcdbus_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdbus_decode
// Unpacks an 18-byte burst into frame fields and range-checks it.
// ----------------------------------------------------------------------------
module rcdbus_decode (
    input  rcdbus_pkg::burst_t              burst,
    input  logic [rcdbus_pkg::CH_W-1:0]     stick_min,
    input  logic [rcdbus_pkg::CH_W-1:0]     stick_max,
    output rcdbus_pkg::frame_t              frame,
    output logic                            bad
);
    import rcdbus_pkg::*;

    logic [CH_W-1:0] ch [4];
    logic [1:0]      s1;
    logic [1:0]      s2;
    logic [3:0]      ch_bad;

    always_comb
    begin
        ch[0] = {burst[1][2:0], burst[0]};
        ch[1] = {burst[2][5:0], burst[1][7:3]};
        ch[2] = {burst[4][0], burst[3], burst[2][7:6]};
        ch[3] = {burst[5][3:0], burst[4][7:1]};
        s1    = burst[5][7:6];
        s2    = burst[5][5:4];

        for (int i = 0; i < 4; i++)
        begin
            ch_bad[i] = (ch[i] > stick_max) || (ch[i] < stick_min);
        end

        frame.sticks   = {ch[3], ch[2], ch[1], ch[0]};
        frame.switches = {s1, s2};
        frame.mouse_x  = {burst[7], burst[6]};
        frame.mouse_y  = {burst[9], burst[8]};
        frame.mouse_z  = {burst[11], burst[10]};
        frame.buttons  = {burst[13], burst[12]};
        frame.keys     = {burst[15], burst[14]};
        frame.wheel    = {burst[17][2:0], burst[16]};

        bad = (s1 == SW_INVALID) || (s2 == SW_INVALID) || (|ch_bad);
    end

endmodule

// ===== hw/rtl/rcdbus_link.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdbus_link
// Held frame, sticky error, loss counter and result forming.
// ----------------------------------------------------------------------------
module rcdbus_link (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          mode,
    input  logic                full,
    input  rcdbus_pkg::frame_t  decoded,
    input  logic                bad,
    input  rcdbus_pkg::cfg_t    cfg,
    output logic                res_valid,
    output rcdbus_pkg::result_t res
);
    import rcdbus_pkg::*;

    logic [LIMIT_W-1:0] ticks_reg;
    logic [LIMIT_W-1:0] ticks_next;
    logic               lost_reg;
    logic               lost_next;
    logic               error_reg;
    logic               error_next;
    frame_t             held_reg;
    frame_t             held_next;
    frame_t             defaults;
    logic [LIMIT_W:0]   tick_inc;

    always_comb
    begin
        defaults.sticks   = {4{cfg.stick_center}};
        defaults.switches = {SW_MIDDLE, SW_MIDDLE};
        defaults.mouse_x  = '0;
        defaults.mouse_y  = '0;
        defaults.mouse_z  = '0;
        defaults.buttons  = '0;
        defaults.keys     = '0;
        defaults.wheel    = cfg.stick_center;

        ticks_next = ticks_reg;
        lost_next  = lost_reg;
        error_next = error_reg;
        held_next  = held_reg;
        res_valid  = 1'b0;
        res.kind   = KIND_FRAME;
        tick_inc   = {1'b0, ticks_reg} + (LIMIT_W + 1)'(1);

        if (accept && mode == MODE_IDLE && full)
        begin
            res_valid  = 1'b1;
            ticks_next = '0;
            if (bad)
            begin
                error_next = 1'b1;
                held_next  = defaults;
            end
            else
            begin
                held_next = decoded;
            end
        end
        else if (accept && mode == MODE_TICK)
        begin
            res_valid = 1'b1;
            res.kind  = KIND_TICK;
            if (tick_inc > {1'b0, cfg.loss_limit})
            begin
                ticks_next = cfg.loss_limit;
                lost_next  = 1'b1;
            end
            else
            begin
                ticks_next = tick_inc[LIMIT_W-1:0];
                lost_next  = 1'b0;
            end
            if (lost_next || error_reg)
            begin
                held_next = defaults;
            end
        end

        res.frame       = held_next;
        res.frame_error = error_next;
        res.link_lost   = lost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg          <= '0;
            lost_reg           <= 1'b0;
            error_reg          <= 1'b0;
            held_reg.sticks    <= {4{STICK_CENTER_RST}};
            held_reg.switches  <= {SW_MIDDLE, SW_MIDDLE};
            held_reg.mouse_x   <= '0;
            held_reg.mouse_y   <= '0;
            held_reg.mouse_z   <= '0;
            held_reg.buttons   <= '0;
            held_reg.keys      <= '0;
            held_reg.wheel     <= STICK_CENTER_RST;
        end
        else
        begin
            ticks_reg <= ticks_next;
            lost_reg  <= lost_next;
            error_reg <= error_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hw/rtl/rcdbus_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdbus_skid
// Output register with one skid entry for the result stream.
// ----------------------------------------------------------------------------
module rcdbus_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rcdbus_pkg::result_t in_res,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output rcdbus_pkg::result_t out_res
);
    import rcdbus_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_res_reg;
    result_t skid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg && out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (in_valid)
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_ready)
        begin
            out_res_reg <= skid_res_reg;
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_res_reg <= in_res;
            end
            else
            begin
                skid_res_reg <= in_res;
            end
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== hw/rtl/rc_dbus_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_dbus_frame_decoder_unit
// Remote-control frame decoder: 18-byte bursts in, decoded frames and
// tick status out.
// ----------------------------------------------------------------------------
// Input beats carry the mode on s_axis_tuser (byte, idle line, timer tick)
// and the received byte on s_axis_tdata. Bytes fill the burst buffer; an
// idle beat after exactly 18 bytes decodes the frame and gives one result
// beat (tuser kind 0), other burst lengths give nothing. A tick beat always
// gives a status beat (tuser kind 1) with the held or safe-default frame.
// One input beat is taken per cycle while s_axis_tready is high. Unpack
// and range check are combinational between the burst registers and the
// output register; a result goes there, or to the skid entry on a stall.
// A stalled receiver is absorbed by an output register plus one skid
// entry: s_axis_tready drops only once both are full.
// Reset clears the burst count, loss counter and flags, loads the register
// defaults and the safe held frame. Config writes are taken on any cycle
// with cfg_wr_en high, and must be made while the block is idle.
// ----------------------------------------------------------------------------
module rc_dbus_frame_decoder_unit #(
    parameter int MAX_BURST = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,  // data_byte
    input  logic [1:0]                             s_axis_tuser,  // mode
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // sticks, switches, mouse_x, mouse_y, mouse_z, buttons, keys, wheel,
    // frame_error, link_lost, zero pad
    output logic [rcdbus_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                   m_axis_tuser,  // kind
    input  logic                                   cfg_wr_en,
    input  logic [rcdbus_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rcdbus_pkg::CH_W-1:0]            cfg_wdata
);
    import rcdbus_pkg::*;

    localparam int RES_DATA_W = $bits(frame_t) + 2;

    cfg_t    cfg_reg;
    logic    accept;
    burst_t  burst;
    logic    full;
    frame_t  decoded;
    logic    bad;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_min    <= STICK_MIN_RST;
            cfg_reg.stick_max    <= STICK_MAX_RST;
            cfg_reg.stick_center <= STICK_CENTER_RST;
            cfg_reg.loss_limit   <= LOSS_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_STICK_MIN:    cfg_reg.stick_min    <= cfg_wdata;
                CFG_STICK_MAX:    cfg_reg.stick_max    <= cfg_wdata;
                CFG_STICK_CENTER: cfg_reg.stick_center <= cfg_wdata;
                CFG_LOSS_LIMIT:   cfg_reg.loss_limit   <= cfg_wdata[LIMIT_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    rcdbus_burst #(
        .MAX_BURST (MAX_BURST)
    ) u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .burst     (burst),
        .full      (full)
    );

    rcdbus_decode u_decode (
        .burst     (burst),
        .stick_min (cfg_reg.stick_min),
        .stick_max (cfg_reg.stick_max),
        .frame     (decoded),
        .bad       (bad)
    );

    rcdbus_link u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (s_axis_tuser),
        .full      (full),
        .decoded   (decoded),
        .bad       (bad),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    rcdbus_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {
        (OUT_TDATA_W - RES_DATA_W)'(0),
        out_res.link_lost,
        out_res.frame_error,
        out_res.frame.wheel,
        out_res.frame.keys,
        out_res.frame.buttons,
        out_res.frame.mouse_z,
        out_res.frame.mouse_y,
        out_res.frame.mouse_x,
        out_res.frame.switches,
        out_res.frame.sticks
    };

endmodule
